/* rtl/dirp_pkg.sv */
package dirp_pkg;

  // Widths of the byte stream, name word and configuration fields
  localparam int DATA_W    = 8;
  localparam int INODE_W   = 32;
  localparam int DIR_LEN_W = 23;
  localparam int CFG_IDX_W = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FILETYPE_PRESENT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIRECTORY_LENGTH = 1'b1;

  // Record layout: byte offsets of header fields within a record
  localparam int FLD_INODE_LAST = 3;
  localparam int FLD_RECLEN_LO  = 4;
  localparam int FLD_RECLEN_HI  = 5;
  localparam int FLD_NAMELEN    = 6;
  localparam int FLD_TYPE       = 7;

  // Header sizes with and without the type byte
  localparam int HDR_WITH_TYPE = 8;
  localparam int HDR_NO_TYPE   = 7;

  // Shortest legal record; also the least room a new record needs
  localparam int MIN_RECORD = 8;

  // Position at which the record length is known and can end a record
  localparam int POS_WRAP_MIN = 6;

  // Largest directory the scan accepts
  localparam int MAX_DIR_BYTES = 4194304;

  // Depth of the queue between parser and output side
  localparam int QUEUE_DEPTH = 2;

  // One name word as it leaves the parser
  typedef struct packed {
    logic [DATA_W-1:0]  name_char;
    logic [INODE_W-1:0] entry_inode;
    logic [DATA_W-1:0]  file_type;
    logic               name_last;
  } dirp_result_t;

endpackage

/* rtl/dirp_if.sv */
interface dirp_in_if;
  import dirp_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_byte;
  logic              first_byte;

  modport source (output valid, output data_byte, output first_byte, input ready);
  modport sink (input valid, input data_byte, input first_byte, output ready);
endinterface

interface dirp_out_if;
  import dirp_pkg::*;

  logic               valid;
  logic               ready;
  logic [DATA_W-1:0]  name_char;
  logic [INODE_W-1:0] entry_inode;
  logic [DATA_W-1:0]  file_type;
  logic               name_last;

  modport source (output valid, output name_char, output entry_inode, output file_type,
                  output name_last, input ready);
  modport sink (input valid, input name_char, input entry_inode, input file_type,
                input name_last, output ready);
endinterface

/* rtl/dirp_parse.sv */
module dirp_parse #(
  parameter int MAX_RECORD_BYTES = 8192
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           filetype_present,
  input  logic [dirp_pkg::DIR_LEN_W-1:0] directory_length,
  dirp_in_if.sink                        din,
  input  logic                           space_ok,
  output logic                           push,
  output dirp_pkg::dirp_result_t         res
);
  import dirp_pkg::*;

  localparam int RL_W  = $clog2(MAX_RECORD_BYTES + 1);
  localparam int PW    = RL_W + 1;
  localparam int CMP_W = ((RL_W > 9) ? RL_W : 9) + 1;

  // Scan state
  logic [DIR_LEN_W-1:0] scan_offset, scan_offset_next;
  logic [RL_W-1:0]      record_position, record_position_next;
  logic                 scan_stopped, scan_stopped_next;
  logic [INODE_W-1:0]   inode_accum, inode_accum_next;
  logic [DATA_W-1:0]    rec_len_low, rec_len_low_next;
  logic [RL_W-1:0]      record_length, record_length_next;
  logic [DATA_W-1:0]    name_length, name_length_next;
  logic [DATA_W-1:0]    type_byte, type_byte_next;

  logic                 accept;
  logic [3:0]           hdr;
  logic [DIR_LEN_W-1:0] eff_offset;
  logic [RL_W-1:0]      eff_pos;
  logic                 eff_stopped;
  logic                 dir_bad;
  logic [PW-1:0]        pos_inc;
  logic [15:0]          full_len;
  logic                 len_bad;
  logic [RL_W-1:0]      rl_cur;
  logic [8:0]           name_end;
  logic                 emit_ok;
  logic                 step_ok;

  assign din.ready = space_ok;
  assign accept    = din.valid && space_ok;

  // Decode the current byte against the record layout
  always_comb begin
    hdr         = filetype_present ? 4'(HDR_WITH_TYPE) : 4'(HDR_NO_TYPE);
    eff_offset  = din.first_byte ? '0 : scan_offset;
    eff_pos     = din.first_byte ? '0 : record_position;
    eff_stopped = din.first_byte ? 1'b0 : scan_stopped;
    dir_bad     = (directory_length == '0) ||
                  (25'(directory_length) > 25'(MAX_DIR_BYTES));
    pos_inc     = PW'(eff_pos) + PW'(1);
    full_len    = {din.data_byte, rec_len_low};
    len_bad     = (full_len < 16'(MIN_RECORD)) ||
                  ({1'b0, full_len} > 17'(MAX_RECORD_BYTES)) ||
                  (25'(eff_offset) + 25'(full_len) >
                   25'(directory_length) + 25'(FLD_RECLEN_HI));
    rl_cur      = (eff_pos == RL_W'(FLD_RECLEN_HI)) ? full_len[RL_W-1:0] : record_length;
    name_end    = 9'(hdr) + 9'(name_length);
    emit_ok     = (CMP_W'(eff_pos) >= CMP_W'(hdr)) && (inode_accum != '0) &&
                  (name_length != '0) && (CMP_W'(name_end) <= CMP_W'(record_length)) &&
                  (CMP_W'(eff_pos) < CMP_W'(name_end));
  end

  // Compute next state and the name word for an accepted byte
  always_comb begin
    scan_offset_next     = scan_offset;
    record_position_next = record_position;
    scan_stopped_next    = scan_stopped;
    inode_accum_next     = inode_accum;
    rec_len_low_next     = rec_len_low;
    record_length_next   = record_length;
    name_length_next     = name_length;
    type_byte_next       = type_byte;
    step_ok              = 1'b0;
    push                 = 1'b0;
    if (accept) begin
      scan_offset_next     = eff_offset;
      record_position_next = eff_pos;
      scan_stopped_next    = eff_stopped;
      if (!eff_stopped) begin
        if (dir_bad) begin
          scan_stopped_next = 1'b1;
        end else begin
          step_ok = 1'b1;
          if (eff_pos == '0) begin
            // Stop when no minimum record fits before the end
            if (24'(eff_offset) + 24'(MIN_RECORD) > 24'(directory_length)) begin
              step_ok = 1'b0;
            end else begin
              inode_accum_next = INODE_W'(din.data_byte);
              type_byte_next   = '0;
            end
          end else if (eff_pos <= RL_W'(FLD_INODE_LAST)) begin
            inode_accum_next = inode_accum |
                               (INODE_W'(din.data_byte) << {eff_pos[1:0], 3'b000});
          end else if (eff_pos == RL_W'(FLD_RECLEN_LO)) begin
            rec_len_low_next = din.data_byte;
          end else if (eff_pos == RL_W'(FLD_RECLEN_HI)) begin
            if (len_bad) begin
              step_ok = 1'b0;
            end else begin
              record_length_next = full_len[RL_W-1:0];
            end
          end else if (eff_pos == RL_W'(FLD_NAMELEN)) begin
            name_length_next = din.data_byte;
          end else if (eff_pos == RL_W'(FLD_TYPE) && filetype_present) begin
            type_byte_next = din.data_byte;
          end
          if (step_ok) begin
            push = emit_ok;
            if (pos_inc >= PW'(POS_WRAP_MIN) && pos_inc >= PW'(rl_cur)) begin
              record_position_next = '0;
            end else begin
              record_position_next = pos_inc[RL_W-1:0];
            end
            scan_offset_next = eff_offset + DIR_LEN_W'(1);
          end else begin
            scan_stopped_next = 1'b1;
          end
        end
      end
    end
  end

  // Form the name word
  always_comb begin
    res.name_char   = din.data_byte;
    res.entry_inode = inode_accum;
    res.file_type   = filetype_present ? type_byte : '0;
    res.name_last   = (CMP_W'(pos_inc) == CMP_W'(name_end));
  end

  // Hold the scan state
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_offset     <= '0;
      record_position <= '0;
      scan_stopped    <= 1'b0;
      inode_accum     <= '0;
      rec_len_low     <= '0;
      record_length   <= '0;
      name_length     <= '0;
      type_byte       <= '0;
    end else begin
      scan_offset     <= scan_offset_next;
      record_position <= record_position_next;
      scan_stopped    <= scan_stopped_next;
      inode_accum     <= inode_accum_next;
      rec_len_low     <= rec_len_low_next;
      record_length   <= record_length_next;
      name_length     <= name_length_next;
      type_byte       <= type_byte_next;
    end
  end

endmodule

/* rtl/dirp_queue.sv */
module dirp_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  dirp_pkg::dirp_result_t wdata,
  output logic                   space_ok,
  dirp_out_if.source             dout
);
  import dirp_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  dirp_result_t     entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             pop;
  dirp_result_t     head;

  assign space_ok = (count != CNT_W'(QUEUE_DEPTH));
  assign pop      = dout.valid && dout.ready;
  assign head     = entries[rd_ptr];

  // Present the oldest word
  assign dout.valid       = (count != '0);
  assign dout.name_char   = head.name_char;
  assign dout.entry_inode = head.entry_inode;
  assign dout.file_type   = head.file_type;
  assign dout.name_last   = head.name_last;

  // Store words as they arrive
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wdata;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

/* rtl/dir_record_stream_parser.sv */
// Directory record stream parser.
// din carries one directory byte per word (data_byte, first_byte); a word
// with first_byte set restarts the scan at offset zero. dout carries one word
// per name byte of every live entry: name_char, entry_inode, file_type and
// name_last on the final byte of a name. Header bytes and unused records
// give no word.
// Configuration is written through cfg_wen/cfg_index/cfg_data while the
// block is idle: index 0 selects 8-byte headers with a type byte, index 1
// sets the directory length in bytes.
// Throughput is one byte per cycle while the queue has room; each byte is
// parsed in the cycle it is accepted; its name word then enters the queue.
// A two-word queue sits between the parser and dout, so din keeps flowing
// while a word waits; din.ready falls only when the queue holds two words
// that dout has not taken.
// Reset clears the scan position, the stop flag, the queue and both
// configuration registers; a scan then needs a nonzero directory length.
module dir_record_stream_parser #(
  parameter int MAX_RECORD_BYTES = 8192
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wen,
  input  logic [dirp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dirp_pkg::DIR_LEN_W-1:0] cfg_data,
  dirp_in_if.sink                        din,
  dirp_out_if.source                     dout
);
  import dirp_pkg::*;

  logic                 filetype_present;
  logic [DIR_LEN_W-1:0] directory_length;
  logic                 push;
  logic                 space_ok;
  dirp_result_t         res;

  // Hold the configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      filetype_present <= 1'b0;
      directory_length <= '0;
    end else if (cfg_wen) begin
      case (cfg_index)
        CFG_FILETYPE_PRESENT: filetype_present <= cfg_data[0];
        CFG_DIRECTORY_LENGTH: directory_length <= cfg_data;
        default: ;
      endcase
    end
  end

  dirp_parse #(
    .MAX_RECORD_BYTES(MAX_RECORD_BYTES)
  ) u_parse (
    .clk              (clk),
    .rst              (rst),
    .filetype_present (filetype_present),
    .directory_length (directory_length),
    .din              (din),
    .space_ok         (space_ok),
    .push             (push),
    .res              (res)
  );

  dirp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wdata    (res),
    .space_ok (space_ok),
    .dout     (dout)
  );

`ifndef SYNTH
  // A name word enters the queue only with an accepted byte
  a_push_on_accept: assert property (@(posedge clk) disable iff (rst)
    push |-> (din.valid && din.ready))
    else $error("name word pushed without an accepted byte");

  // Live entries always carry a nonzero inode
  a_inode_nonzero: assert property (@(posedge clk) disable iff (rst)
    push |-> (res.entry_inode != '0))
    else $error("name word with zero inode");

  // Without type bytes the type field reads zero
  a_type_zero: assert property (@(posedge clk) disable iff (rst)
    (push && !filetype_present) |-> (res.file_type == '0))
    else $error("file type set while type bytes are absent");

  // A full queue always offers a word downstream
  a_full_offers: assert property (@(posedge clk) disable iff (rst)
    !space_ok |-> dout.valid)
    else $error("queue full but no word offered");
`endif

endmodule
